// ===== hw/rtl/pfa_pkg.sv =====
package pfa_pkg;

  localparam int FIELD_W = 40;
  localparam int STATUS_W = 3;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 64;
  localparam int REG_IDX_W = 2;

  localparam logic [63:0] HIGH_START_PAGE = 64'h10_0000;

  localparam logic [STATUS_W-1:0] ST_ALLOC_OK = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FREE_OK = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FREE_ABOVE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FREE_FULL = 3'd4;

  localparam logic [REG_IDX_W-1:0] REG_FIRST_PAGE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_LOW_END_PAGE = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TOP_PAGE = 2'd2;

  localparam logic OP_ALLOC = 1'b0;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } pfa_state_e;

  typedef struct packed {
    logic               operation;
    logic [FIELD_W-1:0] free_page;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0]  alloc_page;
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  used_pages;
  } out_item_t;

endpackage

// ===== hw/rtl/pfa_ram.sv =====
module pfa_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/page_frame_allocator.sv =====
// A bump allocate or any free loads its result beat into the output register from S_EXEC;
// an allocate served from the free queue loads it from S_READ, after the queue memory read.
// A new item is taken only back in S_IDLE; a stalled full output holds S_EXEC or S_READ.
// The output register holds a finished beat while the next item is accepted and worked on.
// Reset (rst_ni low, asynchronous) empties the queue, zeroes the page count, the config
// registers and the bump pointer; no clearing pass runs over the queue memory.
module page_frame_allocator #(
  parameter int FREE_DEPTH = 1024,
  parameter int PAGE_BITS = 40
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  pfa_pkg::in_item_t                    in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output pfa_pkg::out_item_t                   out_data_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pfa_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [pfa_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [pfa_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                 pready
);

  import pfa_pkg::*;

  localparam int PW = PAGE_BITS;
  localparam int AW = $clog2(FREE_DEPTH);
  localparam int CW = $clog2(FREE_DEPTH + 1);

  pfa_state_e state_q, state_d;

  logic          op_q, op_d;
  logic [PW-1:0] page_q, page_d;
  logic [PW-1:0] first_q, first_d;
  logic [PW-1:0] low_q, low_d;
  logic [PW-1:0] top_q, top_d;
  logic [PW-1:0] bump_q, bump_d;
  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic [PW-1:0] used_q, used_d;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_q, out_d;

  logic          ram_re, ram_we;
  logic [PW-1:0] ram_rdata;
  logic          out_free;
  logic          out_load;
  out_item_t     res;
  logic          cfg_we;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic          jump;
  logic [PW-1:0] bump_page;
  logic [PW-1:0] used_inc;
  logic [PW-1:0] used_dec;
  logic [AW-1:0] head_next;
  logic [AW-1:0] tail_next;

  pfa_ram #(
    .WIDTH(PW),
    .DEPTH(FREE_DEPTH)
  ) u_free_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(tail_q),
    .wdata_i(page_q),
    .re_i   (ram_re),
    .raddr_i(head_q),
    .rdata_o(ram_rdata)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign cfg_we = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[APB_ADDR_W-1:3];

  // Near the end of the low region the pointer moves up to HIGH_START_PAGE first.
  assign jump = (low_q != '0) && (bump_q >= low_q - 1'b1) &&
                (64'(bump_q) < HIGH_START_PAGE);
  assign bump_page = jump ? PW'(HIGH_START_PAGE) : bump_q;
  assign used_inc = (&used_q) ? used_q : used_q + 1'b1;
  assign used_dec = (used_q == '0) ? used_q : used_q - 1'b1;
  assign head_next = (head_q == AW'(FREE_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_next = (tail_q == AW'(FREE_DEPTH - 1)) ? '0 : tail_q + 1'b1;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (op_q == OP_ALLOC && count_q != '0) begin
          state_d = S_READ;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_READ: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    op_d = op_q;
    page_d = page_q;
    first_d = first_q;
    low_d = low_q;
    top_d = top_q;
    bump_d = bump_q;
    head_d = head_q;
    tail_d = tail_q;
    count_d = count_q;
    used_d = used_q;
    ram_re = 1'b0;
    ram_we = 1'b0;
    out_load = 1'b0;
    res.alloc_page = '0;
    res.status = ST_ALLOC_OK;
    res.used_pages = FIELD_W'(used_q);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d = in_data_i.operation;
          page_d = PW'(in_data_i.free_page);
        end
      end
      S_EXEC: begin
        if (op_q == OP_ALLOC) begin
          if (count_q != '0) begin
            ram_re = 1'b1;
          end else if (out_free) begin
            out_load = 1'b1;
            if (bump_q >= top_q) begin
              res.status = ST_EXHAUSTED;
            end else begin
              bump_d = bump_page + 1'b1;
              used_d = used_inc;
              res.alloc_page = FIELD_W'(bump_page);
              res.used_pages = FIELD_W'(used_inc);
            end
          end
        end else if (out_free) begin
          out_load = 1'b1;
          if (page_q > bump_q) begin
            res.status = ST_FREE_ABOVE;
          end else if (count_q >= CW'(FREE_DEPTH)) begin
            res.status = ST_FREE_FULL;
          end else begin
            ram_we = 1'b1;
            tail_d = tail_next;
            count_d = count_q + 1'b1;
            used_d = used_dec;
            res.status = ST_FREE_OK;
            res.used_pages = FIELD_W'(used_dec);
          end
        end
      end
      S_READ: begin
        if (out_free) begin
          out_load = 1'b1;
          head_d = head_next;
          count_d = count_q - 1'b1;
          used_d = used_inc;
          res.alloc_page = FIELD_W'(ram_rdata);
          res.used_pages = FIELD_W'(used_inc);
        end
      end
      default: begin
      end
    endcase

    if (cfg_we) begin
      case (cfg_idx)
        REG_FIRST_PAGE: begin
          first_d = PW'(pwdata);
          bump_d = PW'(pwdata);
        end
        REG_LOW_END_PAGE: low_d = PW'(pwdata);
        REG_TOP_PAGE: top_d = PW'(pwdata);
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d = out_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_d = res;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FIRST_PAGE: prdata = APB_DATA_W'(first_q);
      REG_LOW_END_PAGE: prdata = APB_DATA_W'(low_q);
      REG_TOP_PAGE: prdata = APB_DATA_W'(top_q);
      default: prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      first_q <= '0;
      low_q <= '0;
      top_q <= '0;
      bump_q <= '0;
      head_q <= '0;
      tail_q <= '0;
      count_q <= '0;
      used_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
      low_q <= low_d;
      top_q <= top_d;
      bump_q <= bump_d;
      head_q <= head_d;
      tail_q <= tail_d;
      count_q <= count_d;
      used_q <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    page_q <= page_d;
    out_q <= out_d;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(FREE_DEPTH))
    else $error("free queue count above depth");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == CW'(FREE_DEPTH)) |-> head_q == tail_q)
    else $error("queue pointers disagree with an empty or full count");

  a_read_then_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> state_q == S_READ)
    else $error("queue read not followed by its data cycle");

  a_exhausted_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == ST_EXHAUSTED) |-> out_q.alloc_page == '0)
    else $error("exhausted beat carries a page");
`endif

endmodule
